// File: rtl/core/mcgt_pkg.sv
// Package: shared types and constants of the multi-channel glow timer.
`timescale 1ns / 1ps

package mcgt_pkg;

  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned DUR_W    = 22;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned MASK_W   = 16;

  localparam logic [9:0]       US_PER_MS     = 10'd1000;
  localparam logic [DUR_W-1:0] MAX_DUR_RESET = 22'd300000;

  localparam logic REG_MAX_DUR_IDX = 1'b0;

  typedef enum logic [2:0] {
    ST_APPLIED     = 3'd0,
    ST_BAD_CHANNEL = 3'd1,
    ST_ALREADY_LIT = 3'd2,
    ST_TOO_LONG    = 3'd3,
    ST_EXPIRED     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_FLUSH
  } back_state_e;

  // classified request, one queue entry
  typedef struct packed {
    logic              scan;
    logic              bad_chan;
    logic              too_long;
    logic              dur_zero;
    logic [CHAN_W-1:0] chan;
    logic [TIME_W-1:0] limit_us;
    logic [TIME_W-1:0] now_us;
  } mcgt_req_t;

  typedef struct packed {
    status_e           status;
    logic [CHAN_W-1:0] chan;
    logic              lit;
    logic [TIME_W-1:0] event_time;
    logic [MASK_W-1:0] pin_mask;
    logic              last;
  } mcgt_res_t;

endpackage

// File: rtl/core/mcgt_front.sv
// Front end: accepts input transfers, classifies them and scales durations to microseconds.
`timescale 1ns / 1ps

module mcgt_front
  import mcgt_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 10
) (
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic              req_type_i,
  input  logic [CHAN_W-1:0] channel_i,
  input  logic [DUR_W-1:0]  duration_ms_i,
  input  logic [TIME_W-1:0] now_us_i,
  input  logic [DUR_W-1:0]  max_dur_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output mcgt_req_t         q_req_o
);

  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && !q_full_i;

  always_comb begin
    q_req_o.scan     = req_type_i;
    q_req_o.bad_chan = ({1'b0, channel_i} >= (CHAN_W + 1)'(NUM_CHANNELS));
    q_req_o.too_long = (duration_ms_i > max_dur_i);
    q_req_o.dur_zero = (duration_ms_i == '0);
    q_req_o.chan     = channel_i;
    q_req_o.limit_us = TIME_W'(duration_ms_i) * TIME_W'(US_PER_MS);
    q_req_o.now_us   = now_us_i;
  end

endmodule

// File: rtl/core/mcgt_queue.sv
// Two-entry queue between the front end and the channel engine.
`timescale 1ns / 1ps

module mcgt_queue
  import mcgt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  mcgt_req_t din_i,
  output logic      full_o,
  input  logic      pop_i,
  output mcgt_req_t dout_o,
  output logic      empty_o
);

  mcgt_req_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign dout_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i || pop_i;
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

  property p_no_underflow;
    @(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o;
  endproperty
  a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

  property p_count_step;
    @(posedge clk_i) disable iff (!rst_ni)
      (push_i && !pop_i) |=> (count_q == $past(count_q) + 2'd1);
  endproperty
  a_count_step: assert property (p_count_step) else $error("queue count slip");

endmodule

// File: rtl/core/mcgt_back.sv
// Channel engine: applies commands, walks channels on a scan, and registers results.
`timescale 1ns / 1ps

module mcgt_back
  import mcgt_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  mcgt_req_t q_req_i,
  output logic      q_pop_o,
  output logic      m_valid_o,
  input  logic      m_ready_i,
  output mcgt_res_t m_res_o
);

  localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_IDX = CH_W'(NUM_CHANNELS - 1);

  back_state_e             state_q, state_d;
  logic [CH_W-1:0]         idx_q, idx_d;
  logic [TIME_W-1:0]       now_q, now_d;
  logic [NUM_CHANNELS-1:0] lit_q, lit_d;
  logic [TIME_W-1:0]       start_q [NUM_CHANNELS];
  logic [TIME_W-1:0]       limit_q [NUM_CHANNELS];
  logic                    pend_valid_q, pend_valid_d;
  mcgt_res_t               pend_q, pend_d;
  logic                    out_valid_q, out_valid_d;
  mcgt_res_t               out_q, out_d;

  logic              out_free;
  logic [CH_W-1:0]   cidx;
  logic              cur_lit;
  logic              cmd_go;
  logic              start_we;
  logic [TIME_W-1:0] elapsed;
  logic              expired;
  logic              scan_go;
  logic              flush_go;

  assign out_free = !out_valid_q || m_ready_i;
  assign cidx     = q_req_i.chan[CH_W-1:0];
  assign cur_lit  = q_req_i.bad_chan ? 1'b0 : lit_q[cidx];
  assign cmd_go   = (state_q == B_IDLE) && !q_empty_i && !q_req_i.scan && out_free;
  assign elapsed  = now_q - start_q[idx_q];
  assign expired  = lit_q[idx_q] && (elapsed >= limit_q[idx_q]);
  assign scan_go  = (state_q == B_SCAN) && !(expired && pend_valid_q && !out_free);
  assign flush_go = (state_q == B_FLUSH) && (!pend_valid_q || out_free);
  assign q_pop_o  = (state_q == B_IDLE) && !q_empty_i && (q_req_i.scan || out_free);

  assign m_valid_o = out_valid_q;
  assign m_res_o   = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i && q_req_i.scan) begin
          state_d = B_SCAN;
        end
      end
      B_SCAN: begin
        if (scan_go && idx_q == LAST_IDX) begin
          state_d = B_FLUSH;
        end
      end
      B_FLUSH: begin
        if (flush_go) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    idx_d        = idx_q;
    now_d        = now_q;
    lit_d        = lit_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    start_we     = 1'b0;

    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (state_q == B_IDLE && !q_empty_i && q_req_i.scan) begin
      now_d = q_req_i.now_us;
      idx_d = '0;
    end

    if (cmd_go) begin
      out_d.chan       = q_req_i.chan;
      out_d.event_time = q_req_i.now_us;
      out_d.last       = 1'b1;
      priority if (q_req_i.bad_chan) begin
        out_d.status = ST_BAD_CHANNEL;
        out_d.lit    = 1'b0;
      end else if (cur_lit && !q_req_i.dur_zero) begin
        out_d.status = ST_ALREADY_LIT;
        out_d.lit    = 1'b1;
      end else if (q_req_i.too_long) begin
        out_d.status = ST_TOO_LONG;
        out_d.lit    = cur_lit;
      end else if (q_req_i.dur_zero) begin
        out_d.status = ST_APPLIED;
        out_d.lit    = 1'b0;
        lit_d[cidx]  = 1'b0;
      end else begin
        out_d.status = ST_APPLIED;
        out_d.lit    = 1'b1;
        lit_d[cidx]  = 1'b1;
        start_we     = 1'b1;
      end
      out_d.pin_mask = MASK_W'(lit_d);
      out_valid_d    = 1'b1;
    end

    if (scan_go) begin
      if (expired) begin
        lit_d[idx_q] = 1'b0;
        if (pend_valid_q) begin
          out_valid_d = 1'b1;
          out_d       = pend_q;
        end
        pend_valid_d      = 1'b1;
        pend_d.status     = ST_EXPIRED;
        pend_d.chan       = CHAN_W'(idx_q);
        pend_d.lit        = 1'b0;
        pend_d.event_time = now_q;
        pend_d.pin_mask   = MASK_W'(lit_d);
        pend_d.last       = 1'b0;
      end
      if (idx_q != LAST_IDX) begin
        idx_d = idx_q + CH_W'(1);
      end
    end

    if (flush_go && pend_valid_q) begin
      out_valid_d  = 1'b1;
      out_d        = pend_q;
      out_d.last   = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      idx_q        <= '0;
      lit_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      lit_q        <= lit_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    pend_q <= pend_d;
    out_q  <= out_d;
    if (start_we) begin
      start_q[cidx] <= q_req_i.now_us;
      limit_q[cidx] <= q_req_i.limit_us;
    end
  end

  property p_idle_no_pend;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == B_IDLE) |-> !pend_valid_q;
  endproperty
  a_idle_no_pend: assert property (p_idle_no_pend) else $error("pending result left in idle");

  property p_pop_idle;
    @(posedge clk_i) disable iff (!rst_ni) q_pop_o |-> (state_q == B_IDLE);
  endproperty
  a_pop_idle: assert property (p_pop_idle) else $error("queue pop outside idle");

  property p_idx_range;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == B_SCAN) |-> (idx_q <= LAST_IDX);
  endproperty
  a_idx_range: assert property (p_idx_range) else $error("scan index out of range");

  property p_flush_last;
    @(posedge clk_i) disable iff (!rst_ni)
      (flush_go && pend_valid_q) |=> (out_valid_q && out_q.last);
  endproperty
  a_flush_last: assert property (p_flush_last) else $error("scan end without last");

  property p_no_overwrite;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && !m_ready_i) |=> (out_valid_q && $stable(out_q));
  endproperty
  a_no_overwrite: assert property (p_no_overwrite) else $error("output overwritten");

endmodule

// File: rtl/core/multi_channel_glow_timer.sv
// Top level of the multi-channel glow timer: stream ports, APB register, front, queue, engine.
`timescale 1ns / 1ps
// A command passes through the queue and the output register before its result appears.
// A scan walks one channel per cycle while the output is not stalled.
// The engine takes one command per cycle unless the output stalls; a scan holds it to the end.
// A two-entry queue decouples the input from the engine; the output is registered.
// Reset (rst_ni, async low): all channels off, queue and output empty, max 300000 ms.

module multi_channel_glow_timer
  import mcgt_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // channel[3:0], duration_ms[25:4], now_us[57:26]
  input  logic        s_axis_tuser_i,  // req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,  // channel_out[3:0], lit_out[4], event_time[36:5],
                                       // pin_mask[52:37]
  output logic [2:0]  m_axis_tuser_o,  // status
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [DUR_W-1:0] max_dur_q;
  logic             q_full, q_empty, q_push, q_pop;
  mcgt_req_t        q_din, q_dout;
  mcgt_res_t        res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_DUR_IDX) ? 32'(max_dur_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dur_q <= MAX_DUR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_DUR_IDX) begin
      max_dur_q <= pwdata[DUR_W-1:0];
    end
  end

  mcgt_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .req_type_i   (s_axis_tuser_i),
    .channel_i    (s_axis_tdata_i[3:0]),
    .duration_ms_i(s_axis_tdata_i[25:4]),
    .now_us_i     (s_axis_tdata_i[57:26]),
    .max_dur_i    (max_dur_q),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_req_o      (q_din)
  );

  mcgt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .din_i  (q_din),
    .full_o (q_full),
    .pop_i  (q_pop),
    .dout_o (q_dout),
    .empty_o(q_empty)
  );

  mcgt_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .q_req_i  (q_dout),
    .q_pop_o  (q_pop),
    .m_valid_o(m_axis_tvalid_o),
    .m_ready_i(m_axis_tready_i),
    .m_res_o  (res)
  );

  assign m_axis_tdata_o = {3'b000, res.pin_mask, res.event_time, res.lit, res.chan};
  assign m_axis_tuser_o = res.status;
  assign m_axis_tlast_o = res.last;

endmodule

// File: test/mcgt_checker.sv
// Checker for the glow timer: predicts events from input transfers and compares output transfers.
`timescale 1ns / 1ps

module mcgt_checker
  import mcgt_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [63:0] s_tdata_i,  // channel[3:0], duration_ms[25:4], now_us[57:26]
  input  logic        s_tuser_i,  // req_type, high for a scan
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [55:0] m_tdata_i,  // channel_out[3:0], lit_out[4], event_time[36:5],
                                  // pin_mask[52:37]
  input  logic [2:0]  m_tuser_i,  // status
  input  logic        m_tlast_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [2:0] MAX_DUR_ADDR = {REG_MAX_DUR_IDX, 2'b00};

  logic [DUR_W-1:0]  max_dur_q;
  logic              chan_lit   [NUM_CHANNELS];
  logic [TIME_W-1:0] chan_start [NUM_CHANNELS];
  logic [DUR_W-1:0]  chan_dur   [NUM_CHANNELS];
  mcgt_res_t         expected_events[$];
  int                fail_count = 0;

  assign fail_count_o = fail_count;

  function automatic logic [MASK_W-1:0] lit_mask();
    logic [MASK_W-1:0] mask;
    mask = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) mask[i] = chan_lit[i];
    return mask;
  endfunction

  function automatic mcgt_res_t make_event(input status_e st, input logic [CHAN_W-1:0] ch,
                                           input logic lit, input logic [TIME_W-1:0] now);
    mcgt_res_t r;
    r.status     = st;
    r.chan       = ch;
    r.lit        = lit;
    r.event_time = now;
    r.pin_mask   = lit_mask();
    r.last       = 1'b0;
    return r;
  endfunction

  // one transfer in, zero or more events out; last marks the final one
  task automatic predict_glow_events(input logic is_scan, input logic [CHAN_W-1:0] ch,
                                     input logic [DUR_W-1:0] dur,
                                     input logic [TIME_W-1:0] now);
    mcgt_res_t         held;
    bit                have_held;
    logic [TIME_W-1:0] elapsed;
    logic [63:0]       limit_us;
    have_held = 1'b0;
    if (!is_scan) begin
      if (ch >= NUM_CHANNELS) begin
        held = make_event(ST_BAD_CHANNEL, ch, 1'b0, now);
      end else if (chan_lit[ch] && dur != '0) begin
        held = make_event(ST_ALREADY_LIT, ch, 1'b1, now);
      end else if (dur > max_dur_q) begin
        held = make_event(ST_TOO_LONG, ch, chan_lit[ch], now);
      end else if (dur == '0) begin
        chan_lit[ch]   = 1'b0;
        chan_start[ch] = '0;
        chan_dur[ch]   = '0;
        held = make_event(ST_APPLIED, ch, 1'b0, now);
      end else begin
        chan_lit[ch]   = 1'b1;
        chan_start[ch] = now;
        chan_dur[ch]   = dur;
        held = make_event(ST_APPLIED, ch, 1'b1, now);
      end
      have_held = 1'b1;
    end else begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (chan_lit[i]) begin
          elapsed  = now - chan_start[i];
          limit_us = 64'(chan_dur[i]) * 64'(US_PER_MS);
          if (64'(elapsed) >= limit_us) begin
            chan_lit[i]   = 1'b0;
            chan_start[i] = '0;
            chan_dur[i]   = '0;
            if (have_held) expected_events.push_back(held);
            held = make_event(ST_EXPIRED, CHAN_W'(i), 1'b0, now);
            have_held = 1'b1;
          end
        end
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      expected_events.push_back(held);
    end
  endtask

  task automatic report_error(input string msg);
    if (fail_count < 50) $display("%0t ERROR %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mcgt_res_t exp_ev;
    if (!rst_ni) begin
      max_dur_q = MAX_DUR_RESET;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_lit[i]   = 1'b0;
        chan_start[i] = '0;
        chan_dur[i]   = '0;
      end
      expected_events.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == MAX_DUR_ADDR)
        max_dur_q = pwdata_i[DUR_W-1:0];
      if (s_tvalid_i && s_tready_i)
        predict_glow_events(s_tuser_i, s_tdata_i[3:0], s_tdata_i[25:4], s_tdata_i[57:26]);
      if (m_tvalid_i && m_tready_i) begin
        if (expected_events.size() == 0) begin
          report_error($sformatf("unexpected result transfer: channel %0d status %0d",
                                 m_tdata_i[3:0], m_tuser_i));
        end else begin
          exp_ev = expected_events.pop_front();
          check_field("status", 32'(m_tuser_i), 32'(exp_ev.status));
          check_field("channel_out", 32'(m_tdata_i[3:0]), 32'(exp_ev.chan));
          check_field("lit_out", 32'(m_tdata_i[4]), 32'(exp_ev.lit));
          check_field("event_time", m_tdata_i[36:5], exp_ev.event_time);
          check_field("pin_mask", 32'(m_tdata_i[52:37]), 32'(exp_ev.pin_mask));
          check_field("last", 32'(m_tlast_i), 32'(exp_ev.last));
        end
      end
      pending_o <= expected_events.size();
    end
  end

endmodule

// File: test/tb_top.sv
// Testbench top: clock, reset, command/scan stimulus, register writes and the verdict.
`timescale 1ns / 1ps

module tb_top;
  import mcgt_pkg::*;

  localparam int unsigned NUM_CHANNELS = 10;
  localparam logic [2:0]  MAX_DUR_ADDR = {REG_MAX_DUR_IDX, 2'b00};
  localparam logic        REQ_CMD      = 1'b0;
  localparam logic        REQ_SCAN     = 1'b1;
  localparam int          DRAIN_CYCLES = 40;
  localparam logic [TIME_W-1:0] WRAP_T0 = 32'hFFFF_FE00;
  localparam logic [DUR_W-1:0]  DUR_ALL = 22'h3F_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending_events;

  logic [TIME_W-1:0] clock_us;
  logic [DUR_W-1:0]  cur_max = MAX_DUR_RESET;
  bit                burst = 1'b0;
  int                stall_left = 0;
  int                ready_roll;
  bit                ready_free = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  multi_channel_glow_timer #(.NUM_CHANNELS(NUM_CHANNELS)) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tlast_o (m_axis_tlast),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  mcgt_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .m_tlast_i   (m_axis_tlast),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pready_i    (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending_events)
  );

  // output backpressure: mostly short stalls, a few long ones, stretches of free flow
  always @(negedge clk_i) begin
    if ($urandom_range(0, 149) == 0) ready_free = !ready_free;
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (ready_free) begin
      m_axis_tready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 60) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left = (ready_roll < 92) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input logic req, input logic [CHAN_W-1:0] ch,
                           input logic [DUR_W-1:0] dur, input logic [TIME_W-1:0] now);
    int gap;
    if ($urandom_range(0, 24) == 0) burst = !burst;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {6'd0, now, dur, ch};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic scan_at(input logic [TIME_W-1:0] now);
    send_item(REQ_SCAN, CHAN_W'($urandom), DUR_W'($urandom), now);
  endtask

  // a scan with nothing expiring gives no transfer, so allow the engine to finish
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_events != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_max_dur(input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_DUR_ADDR;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_max = data[DUR_W-1:0];
  endtask

  task automatic run_random(input int count);
    int                r;
    logic [CHAN_W-1:0] ch;
    logic [DUR_W-1:0]  dur;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 3) clock_us = $urandom;
      else clock_us = clock_us + $urandom_range(0, 700);
      if ($urandom_range(0, 99) < 50) begin
        scan_at(clock_us);
      end else begin
        ch = ($urandom_range(0, 99) < 85) ? CHAN_W'($urandom_range(0, NUM_CHANNELS - 1))
                                          : CHAN_W'($urandom_range(NUM_CHANNELS, 15));
        r = $urandom_range(0, 99);
        if (r < 10)      dur = '0;
        else if (r < 65) dur = DUR_W'($urandom_range(1, 12));
        else if (r < 80) dur = cur_max + DUR_W'($urandom_range(0, 2)) - DUR_W'(1);
        else if (r < 90) dur = DUR_W'($urandom_range(13, 400));
        else             dur = DUR_W'($urandom);
        send_item(REQ_CMD, ch, dur, clock_us);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // command checks, their order of precedence, and off on an unlit channel
    send_item(REQ_CMD, 4'd0, '0, 32'd0);
    send_item(REQ_CMD, 4'd15, DUR_ALL, 32'hFFFF_FFFF);
    send_item(REQ_CMD, CHAN_W'(NUM_CHANNELS), '0, 32'd5);
    send_item(REQ_CMD, 4'd9, MAX_DUR_RESET, 32'd10);
    send_item(REQ_CMD, 4'd9, 22'd1, 32'd20);
    send_item(REQ_CMD, 4'd9, MAX_DUR_RESET + 22'd1, 32'd30);
    send_item(REQ_CMD, 4'd3, MAX_DUR_RESET + 22'd1, 32'd40);
    send_item(REQ_CMD, 4'd9, '0, 32'd50);
    scan_at(32'd60);
    // all channels lit just before the time wraps, then expired across it
    for (int i = 0; i < NUM_CHANNELS; i++)
      send_item(REQ_CMD, CHAN_W'(i), (i == NUM_CHANNELS - 1) ? 22'd2 : 22'd1, WRAP_T0);
    scan_at(WRAP_T0 + 32'd999);
    scan_at(WRAP_T0 + 32'd1000);
    scan_at(WRAP_T0 + 32'd2000);
    send_item(REQ_CMD, 4'd4, '0, 32'd7);
    wait_drained();

    // widest duration
    write_max_dur({10'd0, DUR_ALL});
    send_item(REQ_CMD, 4'd5, DUR_ALL, 32'h8000_0000);
    scan_at(32'h8000_0000 + 32'd4194302999);
    scan_at(32'h8000_0000 + 32'd4194303000);
    wait_drained();

    clock_us = 32'hFFFF_0000;
    write_max_dur(32'd0);
    run_random(40);
    wait_drained();
    write_max_dur(32'($urandom_range(1, 50)));
    run_random(55);
    wait_drained();
    write_max_dur(32'(MAX_DUR_RESET));
    run_random(60);
    wait_drained();
    write_max_dur($urandom);
    run_random(55);
    wait_drained();

    if (fail_count == 0) begin
      $display("multi_channel_glow_timer test passed");
    end else begin
      $display("multi_channel_glow_timer test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("multi_channel_glow_timer test failed");
    $finish;
  end

endmodule

// File: files.f
rtl/core/mcgt_pkg.sv
rtl/core/mcgt_front.sv
rtl/core/mcgt_queue.sv
rtl/core/mcgt_back.sv
rtl/core/multi_channel_glow_timer.sv
test/mcgt_checker.sv
test/tb_top.sv
